@@ rtl/core/lc_pkg.sv @@
// Shared types and constants for the linear convolution block.
// Used by lc_cell and linear_convolution; depends on nothing else.
package lc_pkg;

  localparam int LC_MAX_TAPS = 16;
  localparam int DATA_W      = 16;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int ACC_W       = 40;

  // Control that the top level hands to each cell of the row.
  typedef struct packed {
    logic shift;   // move the delay line on by one place
    logic clear;   // zero the delay line entry
    logic tap_we;  // write the incoming tap into this cell
    logic active;  // this cell lies inside the loaded kernel
  } lc_cell_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_INJ   = 5'b00100,
    S_SWEEP = 5'b01000,
    S_DLV   = 5'b10000
  } lc_state_t;

endpackage

@@ rtl/core/lc_cell.sv @@
// One cell of the convolution row: a kernel tap, one delay line entry,
// a registered product and a stage of the partial-sum chain. Uses lc_pkg.
module lc_cell
  import lc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  lc_cell_ctl_t             ctl,
  input  logic signed [DATA_W-1:0] tap_in,
  input  logic signed [DATA_W-1:0] x_in,
  output logic signed [DATA_W-1:0] x_out,
  input  logic signed [ACC_W-1:0]  sum_in,
  input  logic                     tok_in,
  output logic signed [ACC_W-1:0]  sum_out,
  output logic                     tok_out
);

  logic signed [DATA_W-1:0] x_r;
  logic signed [DATA_W-1:0] tap_r;
  logic signed [PROD_W-1:0] tap_x;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]  sum_r;
  logic signed [ACC_W-1:0]  sum_nxt;
  logic                     tok_r;

  // The product is formed on its own so that both factors keep their sign.
  assign tap_x    = tap_r * x_r;

  // Cells outside the kernel contribute nothing, so an unwritten tap is never used.
  assign prod_nxt = ctl.active ? tap_x : '0;
  assign sum_nxt  = sum_in + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r   <= '0;
      tok_r <= 1'b0;
    end else begin
      if (ctl.clear) begin
        x_r <= '0;
      end else if (ctl.shift) begin
        x_r <= x_in;
      end
      tok_r <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tap_we) begin
      tap_r <= tap_in;
    end
    prod_r <= prod_nxt;
    if (tok_in) begin
      sum_r <= sum_nxt;
    end
  end

  assign x_out   = x_r;
  assign sum_out = sum_r;
  assign tok_out = tok_r;

endmodule

@@ rtl/core/linear_convolution.sv @@
// Full linear convolution of a signal with a loaded kernel, built as a row
// of MAX_TAPS identical cells, each holding one tap and one delay line entry.
// Words with in_tuser low load kernel taps in order; the tap marked by
// in_tlast sets the kernel length and clears the delay line, and taps past
// MAX_TAPS are dropped. Words with in_tuser high shift a sample in and give
// one result; a sample marked by in_tlast is followed by kernel length - 1
// tail results as if zeros were shifted in, the final one flagged on
// out_tlast. A tap word leaves the block in its idle state, ready for the
// next word. A sample, and each tail result, is worked out in turn:
// the delay line shifts, the cell products are registered, and the partial
// sum then walks the row one cell per cycle before it reaches the output
// register; only then is the next word taken. The output register lets
// the block take the next word while a result still waits to be read.
// Depends on lc_pkg and lc_cell.
module linear_convolution
  import lc_pkg::*;
#(
  parameter int MAX_TAPS = LC_MAX_TAPS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [DATA_W-1:0]       in_tdata,   // [15:0] value
  input  logic                    in_tuser,   // [0] mode: 0 tap, 1 sample
  input  logic                    in_tlast,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [ACC_W-1:0]        out_tdata,  // [39:0] result
  output logic                    out_tlast
);

  localparam int PTR_W = $clog2(MAX_TAPS + 1);

  lc_state_t            state_r, state_nxt;
  logic [PTR_W-1:0]     ptr_r, len_r, tail_r;
  logic [PTR_W-1:0]     ptr_inc;
  logic                 fin_r;
  logic                 out_valid_r;
  logic [ACC_W-1:0]     out_data_r;
  logic                 out_last_r;

  logic                 in_acc, smp_acc, tap_acc;
  logic                 out_free, dlv_go, more_tail, eob;
  logic                 shift_en, clear_en;

  logic signed [DATA_W-1:0] x_chain   [MAX_TAPS+1];
  logic signed [ACC_W-1:0]  sum_chain [MAX_TAPS+1];
  logic [MAX_TAPS:0]        tok_chain;
  lc_cell_ctl_t             cell_ctl  [MAX_TAPS];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign smp_acc   = in_acc & in_tuser;
  assign tap_acc   = in_acc & ~in_tuser;

  assign out_free  = !out_valid_r || out_tready;
  assign dlv_go    = (state_r == S_DLV) && out_free;
  assign more_tail = fin_r && (tail_r != '0);
  assign eob       = fin_r && (tail_r == '0);

  assign shift_en  = smp_acc || (dlv_go && more_tail);
  assign clear_en  = (tap_acc && in_tlast) || (dlv_go && fin_r && !more_tail);
  assign ptr_inc   = (ptr_r < PTR_W'(MAX_TAPS)) ? ptr_r + PTR_W'(1) : ptr_r;

  // Tail terms shift zeros in; only the idle state takes a sample word.
  assign x_chain[0]   = (state_r == S_IDLE) ? $signed(in_tdata) : '0;
  assign sum_chain[0] = '0;
  assign tok_chain[0] = (state_r == S_INJ);

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    assign cell_ctl[k] = '{
      shift:  shift_en,
      clear:  clear_en,
      tap_we: tap_acc && (ptr_r == PTR_W'(k)),
      active: (PTR_W'(k) < len_r)
    };

    lc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (cell_ctl[k]),
      .tap_in  ($signed(in_tdata)),
      .x_in    (x_chain[k]),
      .x_out   (x_chain[k+1]),
      .sum_in  (sum_chain[k]),
      .tok_in  (tok_chain[k]),
      .sum_out (sum_chain[k+1]),
      .tok_out (tok_chain[k+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (smp_acc) state_nxt = S_MUL;
      end
      S_MUL:   state_nxt = S_INJ;
      S_INJ:   state_nxt = S_SWEEP;
      S_SWEEP: begin
        if (tok_chain[MAX_TAPS]) state_nxt = S_DLV;
      end
      S_DLV: begin
        if (out_free) state_nxt = more_tail ? S_MUL : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      len_r       <= '0;
      tail_r      <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (tap_acc) begin
        if (in_tlast) begin
          len_r <= ptr_inc;
          ptr_r <= '0;
        end else begin
          ptr_r <= ptr_inc;
        end
      end
      if (smp_acc) begin
        fin_r  <= in_tlast;
        tail_r <= (in_tlast && len_r != '0) ? len_r - PTR_W'(1) : '0;
      end else if (dlv_go) begin
        if (more_tail) begin
          tail_r <= tail_r - PTR_W'(1);
        end else begin
          fin_r <= 1'b0;
        end
      end
      if (dlv_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dlv_go) begin
      out_data_r <= sum_chain[MAX_TAPS];
      out_last_r <= eob;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  // Only one partial sum may travel along the row at a time.
  assert property (@(posedge clk) disable iff (!rst_n) $onehot0(tok_chain))
    else $error("more than one partial sum in the cell row");

  // A new word is only taken once the row has gone quiet.
  assert property (@(posedge clk) disable iff (!rst_n)
                   in_tready |-> (tok_chain[MAX_TAPS:1] == '0))
    else $error("word accepted while a partial sum is in flight");

  assert property (@(posedge clk) disable iff (!rst_n)
                   (ptr_r <= PTR_W'(MAX_TAPS)) && (len_r <= PTR_W'(MAX_TAPS)))
    else $error("tap pointer or kernel length beyond the row");

  // The final term of a block always leaves the tail bookkeeping cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (dlv_go && eob) |=> !fin_r && (tail_r == '0))
    else $error("tail state not cleared after the final term");
`endif

endmodule

@@ tb/linear_convolution_tb.sv @@
// Self-checking testbench for linear_convolution: kernel loads and signal words go in,
// and every convolution term that comes out is compared with a predictor kept in the bench.
// Depends on lc_pkg and the linear_convolution RTL.
module linear_convolution_tb;
  import lc_pkg::*;

  localparam logic MODE_TAP    = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;
  localparam int   ITEM_TARGET = 450;
  localparam int   SETTLE_CYC  = 3 * (LC_MAX_TAPS + 4);

  typedef struct packed {
    logic [ACC_W-1:0] term;
    logic             eob;
  } conv_term_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata   = '0;  // [15:0] value
  logic              in_tuser   = 1'b0; // [0] mode: 0 tap, 1 sample
  logic              in_tlast   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [ACC_W-1:0]  out_tdata;         // [39:0] result
  logic              out_tlast;

  // Bench copy of the block state.
  logic signed [DATA_W-1:0] coef_q [LC_MAX_TAPS];
  logic signed [DATA_W-1:0] hist_q [LC_MAX_TAPS];
  int unsigned              coef_len = 0;
  int unsigned              coef_wr  = 0;
  conv_term_t               expected_terms [$];

  bit gaps_on    = 1'b1;
  int stall_left = 0;
  int err_count  = 0;
  int words_sent = 0;
  int taps_sent  = 0;
  int samples_sent = 0;
  int terms_seen = 0;
  int ends_seen  = 0;

  linear_convolution u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [ACC_W-1:0] dot_taps();
    longint acc;
    acc = 0;
    for (int k = 0; k < coef_len; k++) begin
      acc += longint'(coef_q[k]) * longint'(hist_q[k]);
    end
    return acc[ACC_W-1:0];
  endfunction

  task automatic shift_hist(input logic signed [DATA_W-1:0] x);
    for (int k = LC_MAX_TAPS - 1; k > 0; k--) begin
      hist_q[k] = hist_q[k-1];
    end
    hist_q[0] = x;
  endtask

  task automatic clear_hist();
    foreach (hist_q[k]) hist_q[k] = '0;
  endtask

  // Works out the terms that one accepted word causes and queues them.
  task automatic convolve_word(input logic mode, input logic [DATA_W-1:0] val,
                               input logic fin);
    int tail;
    conv_term_t t;
    if (mode == MODE_TAP) begin
      if (coef_wr < LC_MAX_TAPS) begin
        coef_q[coef_wr] = val;
        coef_wr++;
      end
      if (fin) begin
        coef_len = coef_wr;
        coef_wr  = 0;
        clear_hist();
      end
    end else begin
      shift_hist(val);
      tail = (fin && coef_len > 0) ? coef_len - 1 : 0;
      t.term = dot_taps();
      t.eob  = fin && (tail == 0);
      expected_terms.push_back(t);
      for (int i = 0; i < tail; i++) begin
        shift_hist('0);
        t.term = dot_taps();
        t.eob  = (i == tail - 1);
        expected_terms.push_back(t);
      end
      if (fin) clear_hist();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [ACC_W-1:0] want,
                                 input logic [ACC_W-1:0] got);
    $display("mismatch on %s at %0t: expected %h, got %h", what, $realtime, want, got);
    err_count++;
  endtask

  // Sends one word, with an occasional idle burst in front of it.
  task automatic send_word(input logic mode, input logic [DATA_W-1:0] val, input logic fin);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_tvalid <= 1'b0;
      in_tdata  <= DATA_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= val;
    in_tuser  <= mode;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    convolve_word(mode, val, fin);
    words_sent++;
    if (mode == MODE_TAP) taps_sent++;
    else samples_sent++;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return '0;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic send_kernel(input int n);
    for (int i = 0; i < n; i++) send_word(MODE_TAP, pick_value(), i == n - 1);
  endtask

  task automatic send_signal(input int n);
    for (int i = 0; i < n; i++) send_word(MODE_SAMPLE, pick_value(), i == n - 1);
  endtask

  // Receiver side: random bursts with out_tready held low while gaps are enabled.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_term
    conv_term_t want;
    if (rst_n && out_tvalid && out_tready) begin
      terms_seen++;
      if (out_tlast) ends_seen++;
      if (expected_terms.size() == 0) begin
        report_mismatch("term with nothing expected", '0, out_tdata);
      end else begin
        want = expected_terms.pop_front();
        if (out_tdata !== want.term) report_mismatch("result", want.term, out_tdata);
        if (out_tlast !== want.eob) begin
          report_mismatch("end of block", ACC_W'(want.eob), ACC_W'(out_tlast));
        end
      end
    end
  end

  // With no kernel loaded every sample gives zero, and a last sample ends the block alone.
  task automatic test_no_kernel();
    send_word(MODE_SAMPLE, 16'h7fff, 1'b0);
    send_word(MODE_SAMPLE, 16'h8000, 1'b1);
  endtask

  task automatic test_single_tap();
    send_word(MODE_TAP, 16'h7fff, 1'b1);
    send_word(MODE_SAMPLE, 16'h8000, 1'b0);
    send_word(MODE_SAMPLE, 16'h7fff, 1'b1);
  endtask

  // Seventeen taps: the last one is dropped but still closes the load at full length.
  task automatic test_tap_overflow();
    for (int i = 0; i < LC_MAX_TAPS; i++) send_word(MODE_TAP, 16'h8000, 1'b0);
    send_word(MODE_TAP, 16'h7fff, 1'b1);
    send_word(MODE_SAMPLE, 16'h8000, 1'b1);
  endtask

  task automatic test_drain_pause();
    send_kernel($urandom_range(2, 6));
    send_signal($urandom_range(2, 5));
    in_tvalid <= 1'b0;
    while (expected_terms.size() != 0) @(posedge clk);
    send_kernel($urandom_range(1, 4));
    send_signal($urandom_range(1, 5));
  endtask

  // Mostly complete kernel and signal runs; a share of loose or interleaved words.
  task automatic test_random_traffic(input int target);
    while (words_sent < target) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_word(logic'($urandom_range(0, 1)), pick_value(),
                    logic'($urandom_range(0, 3) == 0));
        end
      end else begin
        if ($urandom_range(0, 2) != 0) begin
          send_kernel(($urandom_range(0, 9) == 0) ? $urandom_range(14, 20)
                                                   : $urandom_range(1, 6));
        end
        send_signal($urandom_range(1, 10));
      end
    end
  endtask

  task automatic test_steady_stream(input int target);
    gaps_on = 1'b0;
    test_random_traffic(target);
  endtask

  initial begin
    foreach (coef_q[k]) coef_q[k] = '0;
    clear_hist();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_no_kernel();
    test_single_tap();
    test_tap_overflow();
    test_drain_pause();
    test_random_traffic(ITEM_TARGET - 80);
    test_steady_stream(ITEM_TARGET);

    in_tvalid <= 1'b0;
    while (expected_terms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    $display("Sent %0d words: %0d kernel taps and %0d signal samples.",
             words_sent, taps_sent, samples_sent);
    $display("Checked %0d convolution terms, %0d of them closing a block.",
             terms_seen, ends_seen);
    if (err_count == 0 && expected_terms.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
